// ===== src/color_fade_sequencer_defines.svh =====
// Assertion macros for the port-level checker file of the color fade sequencer.
`ifndef COLOR_FADE_SEQUENCER_DEFINES_SVH
`define COLOR_FADE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CFP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("color_fade_sequencer: check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CFP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("color_fade_sequencer: check failed");

`endif

// ===== src/cfp_pkg.sv =====
// Constants, register map and helper functions of the color fade sequencer.
package cfp_pkg;

	localparam int DEF_FRAC_BITS   = 16;
	localparam int DEF_COUNT_WIDTH = 16;

	localparam int COLOR_W = 24;
	localparam int STEPS_W = 16;
	localparam int PHASE_W = STEPS_W + 1;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	// Register indexes, byte address is 4 * index
	localparam logic [2:0] REG_START_COLOR = 3'd0;
	localparam logic [2:0] REG_END_COLOR   = 3'd1;
	localparam logic [2:0] REG_RAMP_STEPS  = 3'd2;
	localparam logic [2:0] REG_LOOP        = 3'd3;
	localparam logic [2:0] REG_REVERSE     = 3'd4;
	localparam logic [2:0] REG_FRAME_TOTAL = 3'd5;

	localparam logic [COLOR_W-1:0] RST_COLOR = 24'hFFFFFF;
	localparam logic [STEPS_W-1:0] RST_ONE   = 16'd1;

	// Channel indexes
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	// Level update applied in one frame tick
	typedef enum logic [1:0] {
		OP_LOAD_START = 2'd0,
		OP_LOAD_END   = 2'd1,
		OP_RAMP       = 2'd2,
		OP_BACK       = 2'd3
	} op_t;

	function automatic logic [7:0] chan_byte(input logic [COLOR_W-1:0] color,
		input logic [1:0] ch);
		logic [7:0] b;
		b = 8'd0;
		case (ch)
			CH_RED:   b = color[23:16];
			CH_GREEN: b = color[15:8];
			CH_BLUE:  b = color[7:0];
			default:  b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

// ===== src/color_fade_sequencer.sv =====
// Linear RGB fade sequencer with loop and ping-pong modes, shared divider and adder.
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  frame in | in_valid, in_ready, restart              | in
//  color out| out_valid, out_ready, red/green/blue_out,| out
//           | frame_index, last_frame                  |
//  config   | psel, penable, pwrite, paddr, pwdata,    | in/out
//           | prdata, pready                           |
//
// A plain frame tick passes from acceptance through one shared add/compare unit, which
// updates red, green and blue in turn, and then the result is registered. A restart tick
// first runs one shared restoring divider, which yields one quotient bit per cycle for
// each channel's step. in_ready is low while a tick is at work and while a finished color
// cannot yet be moved to the output register. Reset is asynchronous; no clearing pass is
// needed.
module color_fade_sequencer import cfp_pkg::*; #(
	parameter int FRAC_BITS   = DEF_FRAC_BITS,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              restart,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        red_out,
	output logic [7:0]        green_out,
	output logic [7:0]        blue_out,
	output logic [15:0]       frame_index,
	output logic              last_frame
);

	localparam int LVL_W = 8 + FRAC_BITS;
	localparam int CNT_W = $clog2(LVL_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LVL_W - 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DLOAD = 5'b00010,
		ST_DRUN = 5'b00100,
		ST_UPD = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [COLOR_W-1:0] start_color_q, end_color_q;
	logic [STEPS_W-1:0] ramp_steps_q, frame_total_q;
	logic               loop_q, reverse_q;

	// Sequence state
	logic [PHASE_W-1:0]     phase_q;
	logic [LVL_W-1:0]       level_q [3];
	logic [LVL_W-1:0]       step_mag_q [3];
	logic                   step_neg_q [3];
	logic [COUNT_WIDTH-1:0] counter_q, idx_q;
	logic                   last_q;
	logic [1:0]             chan_q;

	// Divider
	logic [LVL_W-1:0]   div_num_q;
	logic [STEPS_W-1:0] div_rem_q;
	logic [CNT_W-1:0]   div_cnt_q;

	// Output register
	logic       out_valid_q;
	logic [7:0] red_q, green_q, blue_q;
	logic [15:0] findex_q;
	logic       flast_q;

	logic cfg_wr;
	logic in_fire;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid & in_ready;

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_START_COLOR: prdata = DATA_W'(start_color_q);
			REG_END_COLOR:   prdata = DATA_W'(end_color_q);
			REG_RAMP_STEPS:  prdata = DATA_W'(ramp_steps_q);
			REG_LOOP:        prdata = DATA_W'(loop_q);
			REG_REVERSE:     prdata = DATA_W'(reverse_q);
			REG_FRAME_TOTAL: prdata = DATA_W'(frame_total_q);
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_color_q <= RST_COLOR;
			end_color_q   <= RST_COLOR;
			ramp_steps_q  <= RST_ONE;
			loop_q        <= 1'b0;
			reverse_q     <= 1'b0;
			frame_total_q <= RST_ONE;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_START_COLOR: start_color_q <= pwdata[COLOR_W-1:0];
				REG_END_COLOR:   end_color_q   <= pwdata[COLOR_W-1:0];
				REG_RAMP_STEPS:  ramp_steps_q  <= pwdata[STEPS_W-1:0];
				REG_LOOP:        loop_q        <= pwdata[0];
				REG_REVERSE:     reverse_q     <= pwdata[0];
				REG_FRAME_TOTAL: frame_total_q <= pwdata[STEPS_W-1:0];
				default: ;
			endcase
		end
	end

	// Live sequence parameters
	logic [STEPS_W-1:0] n_eff, divisor, total_m1;
	logic [PHASE_W-1:0] n_ext, top;
	assign n_eff    = (ramp_steps_q == '0) ? RST_ONE : ramp_steps_q;
	assign divisor  = n_eff - RST_ONE;
	assign n_ext    = {1'b0, n_eff};
	assign top      = {n_eff, 1'b0} - PHASE_W'(2);
	assign total_m1 = ((frame_total_q == '0) ? RST_ONE : frame_total_q) - RST_ONE;

	// Phase sequencer: which update this tick applies and where the phase goes
	op_t                op;
	logic [PHASE_W-1:0] phase_next;
	always_comb begin
		op = OP_LOAD_START;
		phase_next = phase_q;
		priority if (phase_q <= n_ext) begin
			if (phase_q == PHASE_W'(1))
				op = OP_LOAD_START;
			else if (phase_q == n_ext)
				op = OP_LOAD_END;
			else
				op = OP_RAMP;
			phase_next = phase_q + PHASE_W'(1);
		end else if (loop_q) begin
			op = OP_LOAD_START;
			phase_next = PHASE_W'(2);
		end else if (reverse_q) begin
			op = OP_BACK;
			phase_next = (phase_q < top) ? phase_q + PHASE_W'(1) : PHASE_W'(1);
		end else begin
			op = OP_LOAD_START;
			phase_next = phase_q;
		end
	end

	// Shared restoring divider step
	logic [STEPS_W:0]   div_trial;
	logic               div_ge;
	logic [STEPS_W-1:0] div_rem_next;
	logic [LVL_W-1:0]   div_num_next;
	assign div_trial    = {div_rem_q, div_num_q[LVL_W-1]};
	assign div_ge       = div_trial >= {1'b0, divisor};
	assign div_rem_next = div_ge ? STEPS_W'(div_trial - {1'b0, divisor})
		: div_trial[STEPS_W-1:0];
	assign div_num_next = {div_num_q[LVL_W-2:0], div_ge};

	// Step magnitude and sign of the channel entering the divider
	logic [7:0]       s_byte, e_byte;
	logic             dl_neg;
	logic [LVL_W-1:0] dl_mag;
	assign s_byte = chan_byte(start_color_q, chan_q);
	assign e_byte = chan_byte(end_color_q, chan_q);
	assign dl_neg = s_byte < e_byte;
	assign dl_mag = LVL_W'(dl_neg ? (e_byte - s_byte) : (s_byte - e_byte)) << FRAC_BITS;

	// Shared level update unit
	logic [LVL_W-1:0] lvl_cur, mag_cur, lvl_new;
	logic [LVL_W:0]   lvl_sum;
	logic             do_sub;
	assign lvl_cur = level_q[chan_q];
	assign mag_cur = step_mag_q[chan_q];
	assign do_sub  = (op == OP_RAMP) ? !step_neg_q[chan_q] : step_neg_q[chan_q];
	assign lvl_sum = {1'b0, lvl_cur} + {1'b0, mag_cur};
	always_comb begin
		lvl_new = lvl_cur;
		unique case (op)
			OP_LOAD_START: lvl_new = LVL_W'(s_byte) << FRAC_BITS;
			OP_LOAD_END:   lvl_new = LVL_W'(e_byte) << FRAC_BITS;
			OP_RAMP, OP_BACK: begin
				if (do_sub)
					lvl_new = (mag_cur > lvl_cur) ? '0 : lvl_cur - mag_cur;
				else
					lvl_new = lvl_sum[LVL_W] ? '1 : lvl_sum[LVL_W-1:0];
			end
		endcase
	end

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PHASE_W'(1);
			counter_q   <= '0;
			idx_q       <= '0;
			last_q      <= 1'b0;
			chan_q      <= CH_RED;
			div_num_q   <= '0;
			div_rem_q   <= '0;
			div_cnt_q   <= '0;
			for (int k = 0; k < 3; k++) begin
				level_q[k]    <= '0;
				step_mag_q[k] <= '0;
				step_neg_q[k] <= 1'b0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						chan_q <= CH_RED;
						if (restart) begin
							idx_q     <= '0;
							counter_q <= COUNT_WIDTH'(1);
							last_q    <= (total_m1 == '0);
							phase_q   <= PHASE_W'(1);
							state_q   <= ST_DLOAD;
						end else begin
							idx_q     <= counter_q;
							counter_q <= counter_q + COUNT_WIDTH'(1);
							last_q    <= (32'(counter_q) == 32'(total_m1));
							state_q   <= ST_UPD;
						end
					end
				end
				ST_DLOAD: begin
					div_num_q          <= dl_mag;
					div_rem_q          <= '0;
					div_cnt_q          <= CNT_LAST;
					step_neg_q[chan_q] <= dl_neg;
					state_q            <= ST_DRUN;
				end
				ST_DRUN: begin
					div_num_q <= div_num_next;
					div_rem_q <= div_rem_next;
					div_cnt_q <= div_cnt_q - CNT_W'(1);
					if (div_cnt_q == '0) begin
						// single-step ramp keeps a zero step
						step_mag_q[chan_q] <= (divisor == '0) ? '0 : div_num_next;
						if (chan_q == CH_BLUE) begin
							chan_q  <= CH_RED;
							state_q <= ST_UPD;
						end else begin
							chan_q  <= chan_q + 2'd1;
							state_q <= ST_DLOAD;
						end
					end
				end
				ST_UPD: begin
					level_q[chan_q] <= lvl_new;
					if (chan_q == CH_BLUE) begin
						phase_q <= phase_next;
						chan_q  <= CH_RED;
						state_q <= ST_EMIT;
					end else begin
						chan_q <= chan_q + 2'd1;
					end
				end
				ST_EMIT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Raise valid on a new result, drop it once the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload, loaded when the result register takes a new transaction
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			red_q    <= level_q[0][LVL_W-1:FRAC_BITS];
			green_q  <= level_q[1][LVL_W-1:FRAC_BITS];
			blue_q   <= level_q[2][LVL_W-1:FRAC_BITS];
			findex_q <= 16'(idx_q);
			flast_q  <= last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign red_out     = red_q;
	assign green_out   = green_q;
	assign blue_out    = blue_q;
	assign frame_index = findex_q;
	assign last_frame  = flast_q;

endmodule

// ===== src/cfp_checker.sv =====
// Port-level checks of the color fade sequencer, bound to the top level.
`include "color_fade_sequencer_defines.svh"

module cfp_checker import cfp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	input logic [DATA_W-1:0] prdata,
	input logic              pready,
	input logic              in_valid,
	input logic              in_ready,
	input logic              restart,
	input logic              out_valid,
	input logic              out_ready,
	input logic [7:0]        red_out,
	input logic [7:0]        green_out,
	input logic [7:0]        blue_out,
	input logic [15:0]       frame_index,
	input logic              last_frame
);

	// A stalled result transaction keeps its payload
	`CFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(frame_index) && $stable(last_frame))

	// Every frame tick keeps the block busy for at least the next cycle
	`CFP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// A new result only follows a cycle of work
	`CFP_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(!in_ready))

endmodule

bind color_fade_sequencer cfp_checker u_cfp_checker (.*);

// ===== bench/cfp_frame_checker.sv =====
// Checker for the color fade sequencer: tracks config writes, predicts each frame, compares.
`timescale 1ns / 100ps
module cfp_frame_checker import cfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              restart,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [7:0]        red_out,
	input  logic [7:0]        green_out,
	input  logic [7:0]        blue_out,
	input  logic [15:0]       frame_index,
	input  logic              last_frame,
	output int                error_count,
	output int                frames_pending
);

	localparam int FRAC      = DEF_FRAC_BITS;
	localparam int LEVEL_TOP = (256 << FRAC) - 1;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] idx;
		logic        last_flag;
	} frame_t;

	// live register copies
	logic [COLOR_W-1:0] cfg_start;
	logic [COLOR_W-1:0] cfg_end;
	logic [STEPS_W-1:0] cfg_steps;
	logic               cfg_loop;
	logic               cfg_rev;
	logic [15:0]        cfg_total;

	// sequencer state
	logic [PHASE_W-1:0]             phase;
	logic signed [24:0]             level [3];
	logic signed [24:0]             step_q [3];
	logic [DEF_COUNT_WIDTH-1:0]     fcount;

	frame_t frames_due[$];
	frame_t got;
	frame_t want;

	function automatic logic [7:0] color_byte(input logic [COLOR_W-1:0] color, input int k);
		return color[16-8*k +: 8];
	endfunction

	function automatic logic signed [24:0] clamp_level(input int v);
		int c;
		c = v;
		if (c < 0)
			c = 0;
		else if (c > LEVEL_TOP)
			c = LEVEL_TOP;
		return c[24:0];
	endfunction

	function automatic logic [7:0] level_byte(input logic signed [24:0] l);
		return l[24] ? 8'd0 : l[23:16];
	endfunction

	function automatic int ramp_len();
		return (cfg_steps == '0) ? 1 : int'(cfg_steps);
	endfunction

	task automatic load_color(input logic [COLOR_W-1:0] color);
		for (int k = 0; k < 3; k++)
			level[k] = {1'b0, color_byte(color, k), {FRAC{1'b0}}};
	endtask

	task automatic shift_levels(input int dir);
		for (int k = 0; k < 3; k++)
			level[k] = clamp_level(int'(level[k]) + dir * int'(step_q[k]));
	endtask

	// per-channel step, truncated toward zero
	task automatic load_steps();
		int n;
		int diff;
		int mag;
		int q;
		n = ramp_len();
		for (int k = 0; k < 3; k++) begin
			diff = int'(color_byte(cfg_start, k)) - int'(color_byte(cfg_end, k));
			mag = ((diff < 0) ? -diff : diff) << FRAC;
			q = (n > 1) ? mag / (n - 1) : 0;
			q = (diff < 0) ? -q : q;
			step_q[k] = q[24:0];
		end
	endtask

	task automatic advance_frame(input logic rs, output frame_t f);
		int n;
		int bounce_end;
		int total;
		logic [15:0] idx;
		n = ramp_len();
		bounce_end = 2 * n - 2;
		total = (cfg_total == '0) ? 1 : int'(cfg_total);
		if (rs) begin
			fcount = '0;
			phase = 17'd1;
			load_steps();
		end
		idx = fcount[15:0];
		if (int'(phase) <= n) begin
			if (phase == 17'd1)
				load_color(cfg_start);
			else if (int'(phase) == n)
				load_color(cfg_end);
			else
				shift_levels(-1);
			phase = phase + 17'd1;
		end else if (cfg_loop) begin
			phase = 17'd2;
			load_color(cfg_start);
		end else if (cfg_rev) begin
			// ping-pong back toward the start color
			shift_levels(1);
			if (int'(phase) < bounce_end)
				phase = phase + 17'd1;
			else
				phase = 17'd1;
		end else begin
			load_color(cfg_start);
		end
		f.red = level_byte(level[0]);
		f.green = level_byte(level[1]);
		f.blue = level_byte(level[2]);
		f.idx = idx;
		f.last_flag = (int'(idx) == total - 1);
		fcount = fcount + 1'b1;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_start = RST_COLOR;
			cfg_end = RST_COLOR;
			cfg_steps = RST_ONE;
			cfg_loop = 1'b0;
			cfg_rev = 1'b0;
			cfg_total = RST_ONE;
			phase = 17'd1;
			fcount = '0;
			for (int k = 0; k < 3; k++) begin
				level[k] = '0;
				step_q[k] = '0;
			end
			frames_due.delete();
			error_count = 0;
		end else begin
			// retire output before input: no frame leaves in the cycle it enters
			if (out_valid && out_ready) begin
				got = {red_out, green_out, blue_out, frame_index, last_frame};
				if (frames_due.size() == 0) begin
					error_count++;
					$display("%0t: frame with none expected: r=%0d g=%0d b=%0d idx=%0d last=%0d",
						$time, got.red, got.green, got.blue, got.idx, got.last_flag);
				end else begin
					want = frames_due.pop_front();
					if (got !== want) begin
						error_count++;
						$display("%0t: expected r=%0d g=%0d b=%0d idx=%0d last=%0d, actual r=%0d g=%0d b=%0d idx=%0d last=%0d",
							$time, want.red, want.green, want.blue, want.idx, want.last_flag,
							got.red, got.green, got.blue, got.idx, got.last_flag);
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_START_COLOR: cfg_start = pwdata[COLOR_W-1:0];
					REG_END_COLOR:   cfg_end = pwdata[COLOR_W-1:0];
					REG_RAMP_STEPS:  cfg_steps = pwdata[STEPS_W-1:0];
					REG_LOOP:        cfg_loop = pwdata[0];
					REG_REVERSE:     cfg_rev = pwdata[0];
					REG_FRAME_TOTAL: cfg_total = pwdata[15:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				advance_frame(restart, want);
				frames_due.push_back(want);
			end
		end
		frames_pending = frames_due.size();
	end

endmodule

// ===== bench/tb_color_fade_sequencer.sv =====
// Testbench top for the color fade sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_color_fade_sequencer;
	import cfp_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic              restart;
	logic              out_valid;
	logic              out_ready;
	logic [7:0]        red_out;
	logic [7:0]        green_out;
	logic [7:0]        blue_out;
	logic [15:0]       frame_index;
	logic              last_frame;
	int                error_count;
	int                frames_pending;

	int   send_idle_pct;
	int   recv_stall_pct;
	int   hold_len;
	logic hold_req;

	color_fade_sequencer u_dut (.*);
	cfp_frame_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#30_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// output side: random stalls, or one long hold-off on request
	initial begin
		logic hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_tick(input logic rs);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		restart <= rs;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid and let every outstanding frame come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (frames_pending == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] sel, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_fade(input logic [23:0] c_start, input logic [23:0] c_end,
		input logic [15:0] n_steps, input logic loop_on, input logic rev_on,
		input logic [15:0] n_frames);
		write_reg(REG_START_COLOR, {8'd0, c_start});
		write_reg(REG_END_COLOR, {8'd0, c_end});
		write_reg(REG_RAMP_STEPS, {16'd0, n_steps});
		write_reg(REG_LOOP, {31'd0, loop_on});
		write_reg(REG_REVERSE, {31'd0, rev_on});
		write_reg(REG_FRAME_TOTAL, {16'd0, n_frames});
	endtask

	function automatic logic [23:0] pick_color();
		int r;
		r = $urandom_range(0, 5);
		if (r == 0)
			return 24'h000000;
		if (r == 1)
			return 24'hFFFFFF;
		return 24'($urandom());
	endfunction

	initial begin
		logic        fresh;
		int          n_items;
		int          r;
		logic [15:0] n_steps;
		logic [15:0] n_frames;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		restart = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_len = 0;
		hold_req = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ticks straight out of reset, no restart yet
		send_tick(1'b0);
		send_tick(1'b0);

		// short ramp, ping-pong, last frame inside the run
		wait_drained();
		set_fade(24'hFF0080, 24'h00FF7F, 16'd4, 1'b0, 1'b1, 16'd6);
		send_tick(1'b1);
		repeat (8) send_tick(1'b0);

		// two-frame ramp full swing, frame total of zero
		wait_drained();
		set_fade(24'h000000, 24'hFFFFFF, 16'd2, 1'b0, 1'b1, 16'd0);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);

		// change start color and ramp length without restart: stale steps saturate
		wait_drained();
		write_reg(REG_START_COLOR, 32'h00FFFFFF);
		write_reg(REG_RAMP_STEPS, 32'd3);
		repeat (4) send_tick(1'b0);

		// zero ramp length in loop mode
		wait_drained();
		set_fade(24'h80FF00, 24'h00007F, 16'd0, 1'b1, 1'b1, 16'd1);
		send_tick(1'b1);
		repeat (2) send_tick(1'b0);

		// longest ramp
		wait_drained();
		set_fade(24'hFFFFFF, 24'h000000, 16'hFFFF, 1'b0, 1'b0, 16'hFFFF);
		send_tick(1'b1);
		send_tick(1'b0);

		for (int ph = 0; ph < 12; ph++) begin
			wait_drained();
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 55; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 55; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			r = $urandom_range(0, 9);
			if (r == 0)
				n_steps = 16'd0;
			else if (r == 1)
				n_steps = 16'd1;
			else if (r == 2)
				n_steps = 16'hFFFF;
			else if (r == 3)
				n_steps = 16'($urandom_range(1000, 65535));
			else
				n_steps = 16'($urandom_range(2, 12));
			r = $urandom_range(0, 7);
			if (r == 0)
				n_frames = 16'd0;
			else if (r == 1)
				n_frames = 16'hFFFF;
			else
				n_frames = 16'($urandom_range(1, 40));
			set_fade(pick_color(), pick_color(), n_steps, $urandom_range(0, 3) == 0,
				1'($urandom_range(0, 1)), n_frames);
			// most phases open with a restart, some carry on with stale steps
			fresh = ($urandom_range(0, 3) != 0);
			if (ph == 4) begin
				hold_len = 300;
				hold_req = 1'b1;
			end
			n_items = $urandom_range(60, 90);
			for (int i = 0; i < n_items; i++)
				send_tick((i == 0 && fresh) || $urandom_range(0, 24) == 0);
		end

		wait_drained();
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/cfp_pkg.sv
src/color_fade_sequencer.sv
src/cfp_checker.sv
bench/cfp_frame_checker.sv
bench/tb_color_fade_sequencer.sv
